// ----- rtl/multiprocessor_job_dispatcher_assert.svh -----
// ----------------------------------------------------------------------------
// multiprocessor job dispatcher assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef MULTIPROCESSOR_JOB_DISPATCHER_ASSERT_SVH
`define MULTIPROCESSOR_JOB_DISPATCHER_ASSERT_SVH

// same-cycle implication, masked during reset
`define MJD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mjd assertion failed");

// next-cycle implication, also checked through reset
`define MJD_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mjd assertion failed");

`endif

// ----- rtl/mjd_pkg.sv -----
// ----------------------------------------------------------------------------
// mjd_pkg
// shared constants, types and codes of the job dispatcher
// ----------------------------------------------------------------------------
package mjd_pkg;

    localparam int MAX_JOBS_DEF = 128;
    localparam int NUM_PROCS    = 5;
    localparam int LEN_W        = 26;
    localparam int TAG_W        = 16;
    localparam int LOAD_W       = 33;
    localparam int SPD_W        = 16;
    localparam int PROC_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_STEPS    = LOAD_W;
    localparam int DIV_CNT_W    = 6;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED4 = 3'd5;

    localparam logic [1:0] POL_SJF   = 2'd0;
    localparam logic [1:0] POL_AWARE = 2'd1;
    localparam logic [1:0] POL_FIFO  = 2'd2;

    localparam logic [PROC_W-1:0] FASTEST_PROC = 3'd4;

    localparam logic [SPD_W-1:0] SPEED_RST [NUM_PROCS] =
        '{16'd2000, 16'd2000, 16'd3000, 16'd3000, 16'd4000};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DWAIT,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rot;
        logic rem;
    } t_cell_ctl;

    typedef struct packed {
        logic              start;
        logic [LOAD_W-1:0] dividend;
        logic [SPD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/mjd_if.sv -----
// ----------------------------------------------------------------------------
// mjd channel interfaces
// job input channel and dispatch result channel
// ----------------------------------------------------------------------------
interface mjd_job_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [mjd_pkg::TAG_W-1:0]  job_id;
    logic [mjd_pkg::LEN_W-1:0]  job_cycles;

    modport source (output valid, mode, job_id, job_cycles, input ready);
    modport sink   (input valid, mode, job_id, job_cycles, output ready);
endinterface

interface mjd_res_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [mjd_pkg::TAG_W-1:0]   out_job_id;
    logic [mjd_pkg::PROC_W-1:0]  processor;
    logic [mjd_pkg::LOAD_W-1:0]  wait_cycles;

    modport source (output valid, status, out_job_id, processor, wait_cycles, input ready);
    modport sink   (input valid, status, out_job_id, processor, wait_cycles, output ready);
endinterface

// ----- rtl/mjd_cell.sv -----
// ----------------------------------------------------------------------------
// mjd_cell
// one job table entry, shifts in from its upper neighbour
// ----------------------------------------------------------------------------
module mjd_cell #(
    parameter int IDX = 0,
    parameter int IW  = 7,
    parameter int CW  = 8
) (
    input  logic                       i_clk,
    input  mjd_pkg::t_cell_ctl         i_ctl,
    input  logic [CW-1:0]              i_count,
    input  logic [IW-1:0]              i_pick,
    input  logic [mjd_pkg::LEN_W-1:0]  i_new_len,
    input  logic [mjd_pkg::TAG_W-1:0]  i_new_tag,
    input  logic [mjd_pkg::LEN_W-1:0]  i_nb_len,
    input  logic [mjd_pkg::TAG_W-1:0]  i_nb_tag,
    output logic [mjd_pkg::LEN_W-1:0]  o_len,
    output logic [mjd_pkg::TAG_W-1:0]  o_tag
);

    logic [mjd_pkg::LEN_W-1:0] r_len;
    logic [mjd_pkg::TAG_W-1:0] r_tag;
    logic                      w_take_nb;
    logic                      w_take_new;

    assign w_take_nb  = i_ctl.rot || (i_ctl.rem && (IW'(IDX) >= i_pick));
    assign w_take_new = i_ctl.load && (CW'(IDX) == i_count);

    always_ff @(posedge i_clk) begin
        if (w_take_nb) begin
            r_len <= i_nb_len;
            r_tag <= i_nb_tag;
        end else if (w_take_new) begin
            r_len <= i_new_len;
            r_tag <= i_new_tag;
        end
    end

    assign o_len = r_len;
    assign o_tag = r_tag;

endmodule

// ----- rtl/mjd_div.sv -----
// ----------------------------------------------------------------------------
// mjd_div
// restoring serial divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module mjd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mjd_pkg::t_div_req i_req,
    output mjd_pkg::t_div_rsp o_rsp
);

    logic [mjd_pkg::LOAD_W-1:0]    r_q;
    logic [mjd_pkg::SPD_W-1:0]     r_rem;
    logic [mjd_pkg::SPD_W-1:0]     r_d;
    logic [mjd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [mjd_pkg::SPD_W:0]       w_trial;
    logic                          w_fit;

    assign w_trial = {r_rem, r_q[mjd_pkg::LOAD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= mjd_pkg::DIV_CNT_W'(mjd_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mjd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            // a zero speed divides as one
            r_d   <= (i_req.divisor == '0) ? mjd_pkg::SPD_W'(1) : i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[mjd_pkg::LOAD_W-2:0], w_fit};
            r_rem <= w_fit ? mjd_pkg::SPD_W'(w_trial - {1'b0, r_d})
                           : w_trial[mjd_pkg::SPD_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// ----- rtl/multiprocessor_job_dispatcher.sv -----
// ----------------------------------------------------------------------------
// multiprocessor job dispatcher
// job table as a chain of cells, least loaded processor pick, job dispatch
// ----------------------------------------------------------------------------
// usage
//   i_job carries items: mode 0 appends (job_id, job_cycles) to the table,
//   mode 1 asks for a dispatch. o_res carries one result per dispatch item
//   and none per load item. the config port writes policy (index 0) and the
//   five processor speeds (indexes 1 to 5); the user must write them only
//   while the block is idle, as the block itself has no check for it.
// loads and dispatch steps
//   back to back loads are accepted every cycle while the block is idle.
//   a dispatch of a non-empty table first picks the processor (one serial
//   divide per processor, 33 quotient bits each, even with speed-aware mode
//   off where the divisor is one), then the table rotates once round the
//   cell chain past the head cell to find the shortest, longest and first
//   job, then the emit state emits the result and closes the gap. an empty
//   table dispatch goes straight to the emit state and answers with status 1.
// reset
//   synchronous, active low: table empty, loads zero, policy 0, speeds to
//   their defaults; table cells are not cleared, only pending entries are read
// stalls
//   the result sits in an output register; a load item is still taken while
//   it waits, a dispatch that finishes meanwhile holds until it is taken.
// ----------------------------------------------------------------------------
module multiprocessor_job_dispatcher #(
    parameter int MaxJobs = mjd_pkg::MAX_JOBS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mjd_job_if.sink                        i_job,
    mjd_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [mjd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mjd_pkg::SPD_W-1:0]      i_cfg_data
);

    localparam int IW = $clog2(MaxJobs);
    localparam int CW = $clog2(MaxJobs + 1);

    // configuration
    logic [1:0]                 r_policy;
    logic [mjd_pkg::SPD_W-1:0]  r_speed [mjd_pkg::NUM_PROCS];

    // control state
    mjd_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_k;
    logic [mjd_pkg::PROC_W-1:0] r_p;
    logic                       r_empty;
    logic [mjd_pkg::LOAD_W-1:0] r_load [mjd_pkg::NUM_PROCS];

    // processor pick
    logic [mjd_pkg::LOAD_W-1:0] r_best_m;
    logic [mjd_pkg::PROC_W-1:0] r_best_p;
    logic [mjd_pkg::LOAD_W-1:0] r_best_wait;

    // job pick
    logic [mjd_pkg::LEN_W-1:0]  r_s_len;
    logic [IW-1:0]              r_s_idx;
    logic [mjd_pkg::TAG_W-1:0]  r_s_tag;
    logic [mjd_pkg::LEN_W-1:0]  r_l_len;
    logic [IW-1:0]              r_l_idx;
    logic [mjd_pkg::TAG_W-1:0]  r_l_tag;
    logic [mjd_pkg::TAG_W-1:0]  r_f_tag;
    logic [mjd_pkg::LEN_W-1:0]  r_f_len;

    // output register
    logic                       r_ov;
    logic                       r_status;
    logic [mjd_pkg::TAG_W-1:0]  r_otag;
    logic [mjd_pkg::PROC_W-1:0] r_oproc;
    logic [mjd_pkg::LOAD_W-1:0] r_owait;

    mjd_pkg::t_cell_ctl         w_ctl;
    mjd_pkg::t_div_req          w_div_req;
    mjd_pkg::t_div_rsp          w_div_rsp;
    logic                       w_div_start;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_emit;
    logic [IW-1:0]              w_pick;
    logic [mjd_pkg::TAG_W-1:0]  w_pick_tag;
    logic [mjd_pkg::LEN_W-1:0]  w_pick_len;
    logic [mjd_pkg::LOAD_W:0]   w_sum;
    logic                       w_in_table;
    logic                       w_longest;

    logic [mjd_pkg::LEN_W-1:0]  w_len [MaxJobs];
    logic [mjd_pkg::TAG_W-1:0]  w_tag [MaxJobs];

    assign w_in_acc   = i_job.valid && i_job.ready;
    assign w_out_free = !r_ov || o_res.ready;
    assign w_emit     = (r_state == mjd_pkg::S_EMIT) && w_out_free;
    assign w_in_table = r_k < r_count;

    // ---- cell chain, each cell fed by its upper neighbour, wrapping round
    for (genvar g = 0; g < MaxJobs; g++) begin : g_cell
        mjd_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_pick    (w_pick),
            .i_new_len (i_job.job_cycles),
            .i_new_tag (i_job.job_id),
            .i_nb_len  (w_len[(g + 1) % MaxJobs]),
            .i_nb_tag  (w_tag[(g + 1) % MaxJobs]),
            .o_len     (w_len[g]),
            .o_tag     (w_tag[g])
        );
    end

    // ---- shared divider for load over speed, or over one unless speed-aware
    assign w_div_req.start    = w_div_start;
    assign w_div_req.dividend = r_load[r_p];
    assign w_div_req.divisor  = (r_policy == mjd_pkg::POL_AWARE) ? r_speed[r_p]
                                                                 : mjd_pkg::SPD_W'(1);

    mjd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---- job choice by policy
    assign w_longest = (r_policy == mjd_pkg::POL_AWARE) && (r_best_p == mjd_pkg::FASTEST_PROC);

    always_comb begin
        if (r_policy == mjd_pkg::POL_FIFO) begin
            w_pick     = '0;
            w_pick_tag = r_f_tag;
        end else if (w_longest) begin
            w_pick     = r_l_idx;
            w_pick_tag = r_l_tag;
        end else begin
            w_pick     = r_s_idx;
            w_pick_tag = r_s_tag;
        end
    end

    // picked length is needed for the load update
    always_comb begin
        if (r_policy == mjd_pkg::POL_FIFO) begin
            w_pick_len = r_f_len;
        end else if (w_longest) begin
            w_pick_len = r_l_len;
        end else begin
            w_pick_len = r_s_len;
        end
    end

    assign w_sum = {1'b0, r_best_wait} + {{(mjd_pkg::LOAD_W + 1 - mjd_pkg::LEN_W){1'b0}},
                                          w_pick_len};

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mjd_pkg::S_IDLE: begin
                if (w_in_acc && i_job.mode) begin
                    n_state = (r_count == '0) ? mjd_pkg::S_EMIT : mjd_pkg::S_DSTART;
                end
            end
            mjd_pkg::S_DSTART: n_state = mjd_pkg::S_DWAIT;
            mjd_pkg::S_DWAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_p == mjd_pkg::PROC_W'(mjd_pkg::NUM_PROCS - 1))
                              ? mjd_pkg::S_SCAN : mjd_pkg::S_DSTART;
                end
            end
            mjd_pkg::S_SCAN: begin
                if (r_k == CW'(MaxJobs - 1)) begin
                    n_state = mjd_pkg::S_EMIT;
                end
            end
            mjd_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = mjd_pkg::S_IDLE;
                end
            end
            default: n_state = mjd_pkg::S_IDLE;
        endcase
    end

    // ---- state outputs
    always_comb begin
        i_job.ready = 1'b0;
        w_div_start = 1'b0;
        w_ctl       = '0;
        unique case (r_state)
            mjd_pkg::S_IDLE: begin
                i_job.ready = 1'b1;
                // a load into a full table is dropped
                w_ctl.load  = w_in_acc && !i_job.mode && (r_count < CW'(MaxJobs));
            end
            mjd_pkg::S_DSTART: w_div_start = 1'b1;
            mjd_pkg::S_DWAIT:  ;
            mjd_pkg::S_SCAN:   w_ctl.rot = 1'b1;
            mjd_pkg::S_EMIT:   w_ctl.rem = w_out_free && !r_empty;
            default:           ;
        endcase
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mjd_pkg::S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_p      <= '0;
            r_empty  <= 1'b0;
            r_ov     <= 1'b0;
            r_policy <= mjd_pkg::POL_SJF;
            for (int p = 0; p < mjd_pkg::NUM_PROCS; p++) begin
                r_speed[p] <= mjd_pkg::SPEED_RST[p];
                r_load[p]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    mjd_pkg::REG_POLICY: r_policy <= i_cfg_data[1:0];
                    [mjd_pkg::REG_SPEED0:mjd_pkg::REG_SPEED4]:
                        r_speed[i_cfg_idx - mjd_pkg::REG_SPEED0] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            if (w_ctl.load) begin
                r_count <= r_count + 1'b1;
            end

            if ((r_state == mjd_pkg::S_IDLE) && w_in_acc && i_job.mode) begin
                r_empty <= (r_count == '0);
                r_p     <= '0;
            end

            if ((r_state == mjd_pkg::S_DWAIT) && w_div_rsp.done) begin
                r_p <= r_p + 1'b1;
                r_k <= '0;
            end

            if (r_state == mjd_pkg::S_SCAN) begin
                r_k <= r_k + 1'b1;
            end

            if (w_emit && !r_empty) begin
                r_count           <= r_count - 1'b1;
                // saturate the running load
                r_load[r_best_p]  <= w_sum[mjd_pkg::LOAD_W] ? '1
                                                            : w_sum[mjd_pkg::LOAD_W-1:0];
            end
        end
    end

    // ---- pick and result registers, no reset needed
    always_ff @(posedge i_clk) begin
        // processor pick, strict compare keeps the lowest index on ties
        if ((r_state == mjd_pkg::S_DWAIT) && w_div_rsp.done) begin
            if ((r_p == '0) || (w_div_rsp.quotient < r_best_m)) begin
                r_best_m    <= w_div_rsp.quotient;
                r_best_p    <= r_p;
                r_best_wait <= r_load[r_p];
            end
        end

        // the head cell shows table entry k during the rotation
        if (r_state == mjd_pkg::S_SCAN) begin
            if (r_k == '0) begin
                r_s_len <= w_len[0];
                r_s_idx <= '0;
                r_s_tag <= w_tag[0];
                r_f_tag <= w_tag[0];
                r_f_len <= w_len[0];
                r_l_idx <= '0;
                r_l_tag <= w_tag[0];
                // longest-first starts from a floor of one cycle
                r_l_len <= (w_len[0] > mjd_pkg::LEN_W'(1)) ? w_len[0] : mjd_pkg::LEN_W'(1);
            end else if (w_in_table) begin
                if (w_len[0] < r_s_len) begin
                    r_s_len <= w_len[0];
                    r_s_idx <= r_k[IW-1:0];
                    r_s_tag <= w_tag[0];
                end
                if (w_len[0] > r_l_len) begin
                    r_l_len <= w_len[0];
                    r_l_idx <= r_k[IW-1:0];
                    r_l_tag <= w_tag[0];
                end
            end
        end

        if (w_emit) begin
            r_status <= r_empty;
            r_otag   <= r_empty ? '0 : w_pick_tag;
            r_oproc  <= r_empty ? '0 : r_best_p;
            r_owait  <= r_empty ? '0 : r_best_wait;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_status;
    assign o_res.out_job_id  = r_otag;
    assign o_res.processor   = r_oproc;
    assign o_res.wait_cycles = r_owait;

endmodule

// ----- rtl/mjd_checker.sv -----
// ----------------------------------------------------------------------------
// mjd_checker
// port level checks of the job dispatcher, bound to the top level
// ----------------------------------------------------------------------------
`include "multiprocessor_job_dispatcher_assert.svh"

module mjd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_status,
    input logic [mjd_pkg::TAG_W-1:0]    i_out_job_id,
    input logic [mjd_pkg::PROC_W-1:0]   i_processor,
    input logic [mjd_pkg::LOAD_W-1:0]   i_wait_cycles
);

    // an empty table answer carries zero fields
    `MJD_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_status,
        (i_out_job_id == '0) && (i_processor == '0) && (i_wait_cycles == '0))

    // processor index stays within the five processors
    `MJD_ASSERT_IMP(a_proc_range, i_clk, i_rst_n, i_out_valid,
        i_processor <= mjd_pkg::PROC_W'(mjd_pkg::NUM_PROCS - 1))

    // a stalled result stays valid and holds its wait cycles and job id
    `MJD_ASSERT_IMP(a_hold, i_clk, i_rst_n, $past(i_out_valid && !i_out_ready) && $past(i_rst_n),
        i_out_valid && $stable(i_wait_cycles) && $stable(i_out_job_id))

    // reset empties the output register
    `MJD_ASSERT_NXT(a_reset, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind multiprocessor_job_dispatcher mjd_checker u_mjd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_out_job_id  (o_res.out_job_id),
    .i_processor   (o_res.processor),
    .i_wait_cycles (o_res.wait_cycles)
);

// ----- tb/sv/mjd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// mjd_tb_pkg
// item types shared by the dispatcher testbench
// ----------------------------------------------------------------------------
package mjd_tb_pkg;

    typedef enum logic {
        MODE_LOAD     = 1'b0,
        MODE_DISPATCH = 1'b1
    } t_mode;

    typedef enum logic {
        ST_DISPATCHED = 1'b0,
        ST_EMPTY      = 1'b1
    } t_status;

    typedef struct packed {
        t_mode                       mode;
        logic [mjd_pkg::TAG_W-1:0]   job_id;
        logic [mjd_pkg::LEN_W-1:0]   job_cycles;
    } t_job_item;

    typedef struct packed {
        t_status                     status;
        logic [mjd_pkg::TAG_W-1:0]   out_job_id;
        logic [mjd_pkg::PROC_W-1:0]  processor;
        logic [mjd_pkg::LOAD_W-1:0]  wait_cycles;
    } t_dispatch_item;

endpackage

// ----- tb/sv/mjd_tb_if.sv -----
// ----------------------------------------------------------------------------
// mjd_tb_if
// configuration write bundle driven by the testbench
// ----------------------------------------------------------------------------
// the block's own channel interfaces (mjd_job_if, mjd_res_if) are used as is;
// this file only holds the register write signals for the driver side
interface mjd_tb_cfg_if;
    logic                          we;
    logic [mjd_pkg::CFG_IDX_W-1:0] idx;
    logic [mjd_pkg::SPD_W-1:0]     data;
endinterface

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// random and directed load/dispatch traffic against a built-in dispatch
// predictor, checked field by field on the result channel
// ----------------------------------------------------------------------------
module testbench;

    localparam int TAG_W     = mjd_pkg::TAG_W;
    localparam int LEN_W     = mjd_pkg::LEN_W;
    localparam int PROC_W    = mjd_pkg::PROC_W;
    localparam int LOAD_W    = mjd_pkg::LOAD_W;
    localparam int SPD_W     = mjd_pkg::SPD_W;
    localparam int CFG_IDX_W = mjd_pkg::CFG_IDX_W;
    localparam int NUM_PROCS = mjd_pkg::NUM_PROCS;

    localparam int                JOBS      = mjd_pkg::MAX_JOBS_DEF;
    localparam logic [LOAD_W-1:0] LOAD_SAT  = {LOAD_W{1'b1}};
    localparam int                IDLE_LIM  = 20000;
    localparam int                DRAIN_CYC = 500;

    logic i_clk;
    logic i_rst_n;

    mjd_job_if    job_ch ();
    mjd_res_if    res_ch ();
    mjd_tb_cfg_if cfg_ch ();

    multiprocessor_job_dispatcher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (cfg_ch.we),
        .i_cfg_idx  (cfg_ch.idx),
        .i_cfg_data (cfg_ch.data)
    );

    // predictor state: policy, speeds, packed job table, loads
    logic [1:0]        pol_q;
    logic [SPD_W-1:0]  speed_q [NUM_PROCS];
    logic [LEN_W-1:0]  tab_len [$];
    logic [TAG_W-1:0]  tab_tag [$];
    logic [LOAD_W-1:0] load_q  [NUM_PROCS];

    mjd_tb_pkg::t_job_item      pending_jobs [$];
    mjd_tb_pkg::t_dispatch_item expected_dispatch [$];

    int  mismatches;
    int  idle_cycles;
    bit  timed_out;
    bit  in_taken;
    int  burst_left;
    int  gap_left;
    int  stall_left;
    int  run_left;

    // clock, period 12
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // register write applied to the predictor as well
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPD_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.we   <= 1'b1;
        cfg_ch.idx  <= idx;
        cfg_ch.data <= val;
        @(negedge i_clk);
        cfg_ch.we   <= 1'b0;
        if (idx == mjd_pkg::REG_POLICY) pol_q = val[1:0];
        else if (idx >= mjd_pkg::REG_SPEED0 && idx <= mjd_pkg::REG_SPEED4)
            speed_q[idx - mjd_pkg::REG_SPEED0] = val;
    endtask

    // queues one item for the driver
    task automatic add_job(input mjd_tb_pkg::t_job_item j);
        pending_jobs.insert(pending_jobs.size(), j);
    endtask

    // works out the dispatch result and updates table and loads
    function automatic mjd_tb_pkg::t_dispatch_item predict_dispatch();
        mjd_tb_pkg::t_dispatch_item r;
        logic [LOAD_W-1:0] best_m, m, div;
        logic [LOAD_W:0]   sum;
        logic [LEN_W-1:0]  best_len;
        int proc, pick;
        bit aware;
        r = '0;
        if (tab_len.size() == 0) begin
            r.status = mjd_tb_pkg::ST_EMPTY;
            return r;
        end
        aware = (pol_q == mjd_pkg::POL_AWARE);
        proc = 0;
        best_m = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            div = (speed_q[p] == '0) ? LOAD_W'(1) : LOAD_W'(speed_q[p]);
            m = aware ? load_q[p] / div : load_q[p];
            if (p == 0 || m < best_m) begin
                best_m = m;
                proc = p;
            end
        end
        pick = 0;
        if (pol_q == mjd_pkg::POL_FIFO) begin
            pick = 0;
        end else if (aware && proc == NUM_PROCS - 1) begin
            // longest first; nothing above one cycle leaves the head
            best_len = LEN_W'(1);
            for (int i = 0; i < tab_len.size(); i++)
                if (tab_len[i] > best_len) begin
                    best_len = tab_len[i];
                    pick = i;
                end
        end else begin
            for (int i = 1; i < tab_len.size(); i++)
                if (tab_len[i] < tab_len[pick]) pick = i;
        end
        r.status      = mjd_tb_pkg::ST_DISPATCHED;
        r.out_job_id  = tab_tag[pick];
        r.processor   = PROC_W'(proc);
        r.wait_cycles = load_q[proc];
        sum = {1'b0, load_q[proc]} + {{(LOAD_W + 1 - LEN_W){1'b0}}, tab_len[pick]};
        load_q[proc] = sum[LOAD_W] ? LOAD_SAT : sum[LOAD_W-1:0];
        tab_len.delete(pick);
        tab_tag.delete(pick);
        return r;
    endfunction

    // driver: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            job_ch.valid <= 1'b0;
        end else if (job_ch.valid && !in_taken) begin
            // hold the offered item
        end else begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                job_ch.valid <= 1'b0;
            end else if (pending_jobs.size() > 0) begin
                job_ch.valid      <= 1'b1;
                job_ch.mode       <= pending_jobs[0].mode;
                job_ch.job_id     <= pending_jobs[0].job_id;
                job_ch.job_cycles <= pending_jobs[0].job_cycles;
                void'(pending_jobs.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                job_ch.valid <= 1'b0;
            end
        end
        // receiver stall pattern: runs of ready, then runs of stall
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left     <= run_left - 1;
            res_ch.ready <= 1'b1;
        end else begin
            run_left   <= $urandom_range(1, 40);
            stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            res_ch.ready <= 1'b1;
        end
    end

    // monitor: predictor on accepted items, checks on accepted results
    always @(posedge i_clk) begin
        mjd_tb_pkg::t_job_item      it;
        mjd_tb_pkg::t_dispatch_item got, exp_r;
        bit                         moved;
        moved = 1'b0;
        in_taken <= job_ch.valid && job_ch.ready;
        if (i_rst_n) begin
            if (job_ch.valid && job_ch.ready) begin
                moved = 1'b1;
                it.mode       = mjd_tb_pkg::t_mode'(job_ch.mode);
                it.job_id     = job_ch.job_id;
                it.job_cycles = job_ch.job_cycles;
                if (it.mode == mjd_tb_pkg::MODE_LOAD) begin
                    // a full table drops the item
                    if (tab_len.size() < JOBS) begin
                        tab_len.insert(tab_len.size(), it.job_cycles);
                        tab_tag.insert(tab_tag.size(), it.job_id);
                    end
                end else begin
                    expected_dispatch.insert(expected_dispatch.size(), predict_dispatch());
                end
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                got.status      = mjd_tb_pkg::t_status'(res_ch.status);
                got.out_job_id  = res_ch.out_job_id;
                got.processor   = res_ch.processor;
                got.wait_cycles = res_ch.wait_cycles;
                if (expected_dispatch.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", got);
                end else begin
                    exp_r = expected_dispatch.pop_front();
                    if (got.status != exp_r.status || got.out_job_id != exp_r.out_job_id ||
                        got.processor != exp_r.processor ||
                        got.wait_cycles != exp_r.wait_cycles) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", exp_r, got);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIM && !timed_out) begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    function automatic mjd_tb_pkg::t_job_item make_load(input logic [TAG_W-1:0] id,
                                                        input logic [LEN_W-1:0] len);
        mjd_tb_pkg::t_job_item j;
        j.mode = mjd_tb_pkg::MODE_LOAD;
        j.job_id = id;
        j.job_cycles = len;
        return j;
    endfunction

    function automatic mjd_tb_pkg::t_job_item make_dispatch();
        mjd_tb_pkg::t_job_item j;
        j.mode = mjd_tb_pkg::MODE_DISPATCH;
        j.job_id = TAG_W'($urandom());
        j.job_cycles = LEN_W'($urandom());
        return j;
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 5))
            0: return LEN_W'($urandom_range(0, 1));
            1: return {LEN_W{1'b1}};
            2: return LEN_W'($urandom_range(0, 7));
            3: return LEN_W'($urandom_range(0, 1000));
            default: return LEN_W'($urandom());
        endcase
    endfunction

    // waits till every expected result is in, then lets the block settle
    task automatic wait_idle();
        while (pending_jobs.size() > 0 || job_ch.valid || expected_dispatch.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // one phase of random traffic: mostly load bursts then dispatches
    task automatic random_phase(input int n_items);
        int n;
        int k;
        n = 0;
        while (n < n_items) begin
            k = $urandom_range(0, 10);
            repeat (k) begin
                add_job(make_load(TAG_W'($urandom()), rand_len()));
                n++;
            end
            k = $urandom_range(0, 8);
            repeat (k) begin
                add_job(make_dispatch());
                n++;
            end
        end
    endtask

    initial begin
        logic [SPD_W-1:0] spd;
        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 0;
        in_taken    = 0;
        burst_left  = 0;
        gap_left    = 0;
        stall_left  = 0;
        run_left    = 0;
        job_ch.valid      = 1'b0;
        job_ch.mode       = 1'b0;
        job_ch.job_id     = '0;
        job_ch.job_cycles = '0;
        res_ch.ready      = 1'b0;
        cfg_ch.we   = 1'b0;
        cfg_ch.idx  = '0;
        cfg_ch.data = '0;
        pol_q = mjd_pkg::POL_SJF;
        for (int p = 0; p < NUM_PROCS; p++) begin
            speed_q[p] = mjd_pkg::SPEED_RST[p];
            load_q[p]  = '0;
        end
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty dispatch, extremes, ties, shortest first
        add_job(make_dispatch());
        add_job(make_load(16'h0000, '0));
        add_job(make_load(16'hFFFF, {LEN_W{1'b1}}));
        add_job(make_load(16'h5555, 26'h2AAAAAA));
        add_job(make_load(16'hAAAA, '0));
        add_job(make_load(16'h1234, 26'd1));
        repeat (6) add_job(make_dispatch());
        wait_idle();

        // fifo policy, then speed-aware with long jobs
        write_reg(mjd_pkg::REG_POLICY, SPD_W'(mjd_pkg::POL_FIFO));
        for (int i = 0; i < 4; i++) add_job(make_load(TAG_W'(i), LEN_W'(5 - i)));
        repeat (4) add_job(make_dispatch());
        wait_idle();
        write_reg(mjd_pkg::REG_POLICY, SPD_W'(mjd_pkg::POL_AWARE));
        // longest first with nothing above one cycle takes the head
        for (int i = 0; i < 3; i++) add_job(make_load(TAG_W'(16'h100 + i), 26'd1));
        for (int i = 0; i < 3; i++) add_job(make_load(TAG_W'(16'h200 + i), {LEN_W{1'b1}}));
        repeat (6) add_job(make_dispatch());
        wait_idle();
        // unused policy code three, zero speeds, table overflow
        write_reg(mjd_pkg::REG_POLICY, 16'd3);
        for (int r = mjd_pkg::REG_SPEED0; r <= mjd_pkg::REG_SPEED4; r++)
            write_reg(CFG_IDX_W'(r), '0);
        for (int i = 0; i < JOBS + 3; i++)
            add_job(make_load(TAG_W'(i), LEN_W'($urandom())));
        random_phase(60);
        wait_idle();

        // random phases through several settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(mjd_pkg::REG_POLICY,
                      SPD_W'((ph < 6) ? ph % 3 : $urandom_range(0, 3)));
            for (int r = mjd_pkg::REG_SPEED0; r <= mjd_pkg::REG_SPEED4; r++) begin
                case ($urandom_range(0, 3))
                    0: spd = 16'd1;
                    1: spd = 16'hFFFF;
                    2: spd = mjd_pkg::SPEED_RST[r - mjd_pkg::REG_SPEED0];
                    default: spd = SPD_W'($urandom());
                endcase
                write_reg(CFG_IDX_W'(r), spd);
            end
            random_phase(220);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
